@@ design/m3dec_pkg.sv @@
// ----------------------------------------------------------------------------
// m3dec_pkg
// Shared types, table masks and operation bases for the MIPS III decoder.
// ----------------------------------------------------------------------------
package m3dec_pkg;

  // Validity masks of the decode tables, bit n set when slot n holds an op.
  localparam logic [63:0] PRIM_MASK  = 64'hF7F77FFF0FF0FFFC;
  localparam logic [63:0] SPEC_MASK  = 64'hDD5FFCFFFFDF93DD;
  localparam logic [63:0] RIMM_MASK  = 64'h00000000000F5F0F;
  localparam logic [63:0] CACHE_MASK = 64'h0000000003332333;
  localparam logic [63:0] COP0_MASK  = 64'h0000000001000146;
  localparam logic [63:0] FPU_MASK   = 64'hFFFF00330000FFFF;

  localparam logic [7:0] BASE_PRIM   = 8'd0;
  localparam logic [7:0] BASE_SPEC   = 8'd51;
  localparam logic [7:0] BASE_RIMM   = 8'd102;
  localparam logic [7:0] BASE_CACHE  = 8'd116;
  localparam logic [7:0] BASE_COP0   = 8'd129;
  localparam logic [7:0] BASE_FPU    = 8'd134;
  localparam logic [7:0] OP_NONE     = 8'd0;
  localparam logic [7:0] OP_COP2     = 8'd171;
  localparam logic [7:0] OP_BC_BASE  = 8'd172;
  localparam logic [7:0] OP_CFC_BASE = 8'd184;
  localparam logic [7:0] OP_MTC0     = 8'd187;
  localparam logic [7:0] OP_MFC0     = 8'd188;
  localparam logic [7:0] OP_DMTC0    = 8'd189;
  localparam logic [7:0] OP_DMFC0    = 8'd190;

  // Format classes
  localparam logic [2:0] CLS_REG   = 3'd0;
  localparam logic [2:0] CLS_RIMM  = 3'd1;
  localparam logic [2:0] CLS_JUMP  = 3'd2;
  localparam logic [2:0] CLS_IMM   = 3'd3;
  localparam logic [2:0] CLS_CACHE = 3'd4;
  localparam logic [2:0] CLS_COP   = 3'd5;

  // Primary opcodes with a sub-table of their own, and the two jumps
  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_REGIMM  = 6'd1;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_COP0    = 6'd16;
  localparam logic [5:0] OPC_COP3    = 6'd19;
  localparam logic [5:0] OPC_CACHE   = 6'd47;

  // Coprocessor rs forms
  localparam logic [4:0] RS_MF  = 5'd0;
  localparam logic [4:0] RS_DMF = 5'd1;
  localparam logic [4:0] RS_CF  = 5'd2;
  localparam logic [4:0] RS_MT  = 5'd4;
  localparam logic [4:0] RS_DMT = 5'd5;
  localparam logic [4:0] RS_BC  = 5'd8;

  localparam logic [1:0] COP_FPU  = 2'd1;
  localparam logic [1:0] COP_SYS  = 2'd0;
  localparam logic [1:0] COP_GFX  = 2'd2;
  localparam logic [1:0] COP_LAST = 2'd3;

  // Per-table lookups, registered at the end of the table stage
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [7:0]  prim_op;
    logic [7:0]  spec_op;
    logic [7:0]  rimm_op;
    logic [7:0]  cch_op;
    logic [7:0]  cop_op;
  } lkup_t;

  // Dense number of a slot in a table; the mask is constant, so this folds
  // into a 64-entry lookup.
  function automatic logic [7:0] rank_in(logic [63:0] mask, logic [5:0] idx,
                                         logic [7:0] base);
    logic [7:0] cnt;
    cnt = 8'd0;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) < idx) cnt = cnt + 8'(mask[i]);
    end
    return mask[idx] ? 8'(base + cnt + 8'd1) : OP_NONE;
  endfunction

endpackage

@@ design/mips3_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// mips3_instruction_decoder
// Three-stage pipelined decoder for 32-bit MIPS III instruction words.
// ----------------------------------------------------------------------------
// One instruction word is taken every clock cycle: busy is held low, so a
// word is accepted at every edge where start is high. Each word gives exactly
// one result, shown on the out_ ports for one cycle with out_valid high,
// once it has passed the input register, table lookup register and
// select/output register. The receiver cannot stall the block and has to
// take every result in the cycle it appears. The decoder keeps no state
// between words; reset clears the valid bits and the table register. Empty
// table slots and unsupported coprocessor forms give out_is_invalid high and
// op code zero; the raw bit fields always follow the word.
module mips3_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  output logic        out_is_invalid,
  output logic [2:0]  out_format_class,
  output logic [7:0]  out_op_code,
  output logic [1:0]  out_cop_number,
  output logic [4:0]  out_rs_field,
  output logic [4:0]  out_rt_field,
  output logic [4:0]  out_rd_field,
  output logic [4:0]  out_shift_amount,
  output logic [5:0]  out_funct_field,
  output logic [15:0] out_imm_value,
  output logic [25:0] out_jump_target
);
  import m3dec_pkg::*;

  logic        vld_r;
  logic [31:0] word_r;
  lkup_t       lkup;
  logic [31:0] out_word;

  // Never hold off the source: every stage advances every cycle.
  assign busy = 1'b0;

  // Stage 1: capture the word.
  always_ff @(posedge clk) begin
    word_r <= in_instr_word;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
  end

  // Stage 2: look up every decode table in parallel.
  m3dec_tbl u_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_r),
    .word_i (word_r),
    .lkup_o (lkup)
  );

  // Stage 3: select by primary opcode and register the result.
  m3dec_sel u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .lkup_i    (lkup),
    .vld_o     (out_valid),
    .invalid_o (out_is_invalid),
    .cls_o     (out_format_class),
    .op_o      (out_op_code),
    .word_o    (out_word)
  );

  // Raw slices of the decoded word
  assign out_cop_number   = out_word[27:26];
  assign out_rs_field     = out_word[25:21];
  assign out_rt_field     = out_word[20:16];
  assign out_rd_field     = out_word[15:11];
  assign out_shift_amount = out_word[10:6];
  assign out_funct_field  = out_word[5:0];
  assign out_imm_value    = out_word[15:0];
  assign out_jump_target  = out_word[25:0];

endmodule

@@ design/m3dec_tbl.sv @@
// ----------------------------------------------------------------------------
// m3dec_tbl
// Table stage: look the word up in every decode table in parallel.
// ----------------------------------------------------------------------------
module m3dec_tbl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [31:0]       word_i,
  output m3dec_pkg::lkup_t  lkup_o
);
  import m3dec_pkg::*;

  logic [5:0] opc;
  logic [1:0] cop;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [5:0] fn;
  logic [7:0] cop_op;
  lkup_t      lkup_r;
  lkup_t      lkup_nxt;

  assign opc = word_i[31:26];
  assign cop = word_i[27:26];
  assign rs  = word_i[25:21];
  assign rt  = word_i[20:16];
  assign fn  = word_i[5:0];

  // Coprocessor forms: function bit, then the move and branch rs codes
  always_comb begin
    cop_op = OP_NONE;
    if (rs[4]) begin
      case (cop)
        COP_FPU: cop_op = rank_in(FPU_MASK, fn, BASE_FPU);
        COP_SYS: cop_op = rank_in(COP0_MASK, fn, BASE_COP0);
        COP_GFX: cop_op = OP_COP2;
        default: cop_op = OP_NONE;
      endcase
    end else begin
      case (rs)
        RS_MF:   cop_op = OP_MFC0;
        RS_DMF:  cop_op = OP_DMFC0;
        RS_MT:   cop_op = OP_MTC0;
        RS_DMT:  cop_op = OP_DMTC0;
        RS_CF:   cop_op = (cop != COP_LAST) ? 8'(OP_CFC_BASE + 8'(cop)) : OP_NONE;
        RS_BC: begin
          if (rt[4:2] == 3'd0 && cop != COP_LAST)
            cop_op = 8'(OP_BC_BASE + 8'd3 * 8'(rt[1:0]) + 8'(cop));
          else
            cop_op = OP_NONE;
        end
        default: cop_op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    lkup_nxt.valid    = vld_i;
    lkup_nxt.word     = word_i;
    lkup_nxt.prim_op  = rank_in(PRIM_MASK, opc, BASE_PRIM);
    lkup_nxt.spec_op  = rank_in(SPEC_MASK, fn, BASE_SPEC);
    lkup_nxt.rimm_op  = rank_in(RIMM_MASK, {1'b0, rt}, BASE_RIMM);
    lkup_nxt.cch_op   = rank_in(CACHE_MASK, {1'b0, rt}, BASE_CACHE);
    lkup_nxt.cop_op   = cop_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkup_r <= '0;
    end else begin
      lkup_r <= lkup_nxt;
    end
  end

  assign lkup_o = lkup_r;

endmodule

@@ design/m3dec_sel.sv @@
// ----------------------------------------------------------------------------
// m3dec_sel
// Select stage: pick the table by primary opcode, set class and output word.
// ----------------------------------------------------------------------------
module m3dec_sel (
  input  logic              clk,
  input  logic              rst_n,
  input  m3dec_pkg::lkup_t  lkup_i,
  output logic              vld_o,
  output logic              invalid_o,
  output logic [2:0]        cls_o,
  output logic [7:0]        op_o,
  output logic [31:0]       word_o
);
  import m3dec_pkg::*;

  logic [5:0]  opc;
  logic [7:0]  op_nxt;
  logic [2:0]  cls_nxt;
  logic        vld_r;
  logic [7:0]  op_r;
  logic [2:0]  cls_r;
  logic [31:0] word_r;

  assign opc = lkup_i.word[31:26];

  always_comb begin
    if (opc == OPC_SPECIAL) begin
      cls_nxt = CLS_REG;
      op_nxt  = lkup_i.spec_op;
    end else if (opc == OPC_REGIMM) begin
      cls_nxt = CLS_RIMM;
      op_nxt  = lkup_i.rimm_op;
    end else if (opc inside {[OPC_COP0:OPC_COP3]}) begin
      cls_nxt = CLS_COP;
      op_nxt  = lkup_i.cop_op;
    end else if (opc == OPC_CACHE) begin
      cls_nxt = CLS_CACHE;
      op_nxt  = lkup_i.cch_op;
    end else begin
      op_nxt = lkup_i.prim_op;
      if (lkup_i.prim_op == OP_NONE)
        cls_nxt = CLS_REG;
      else if (opc == OPC_J || opc == OPC_JAL)
        cls_nxt = CLS_JUMP;
      else
        cls_nxt = CLS_IMM;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cls_r  <= cls_nxt;
    word_r <= lkup_i.word;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= lkup_i.valid;
    end
  end

  assign vld_o     = vld_r;
  assign invalid_o = (op_r == OP_NONE);
  assign cls_o     = cls_r;
  assign op_o      = op_r;
  assign word_o    = word_r;

endmodule

@@ design/m3dec_chk.sv @@
// ----------------------------------------------------------------------------
// m3dec_chk
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module m3dec_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_instr_word,
  input logic        out_valid,
  input logic        out_is_invalid,
  input logic [2:0]  out_format_class,
  input logic [7:0]  out_op_code,
  input logic [1:0]  out_cop_number,
  input logic [4:0]  out_rs_field,
  input logic [4:0]  out_rt_field,
  input logic [4:0]  out_rd_field,
  input logic [4:0]  out_shift_amount,
  input logic [5:0]  out_funct_field,
  input logic [15:0] out_imm_value,
  input logic [25:0] out_jump_target
);
  import m3dec_pkg::*;

  // Every accepted word, with no reset in between, gives a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(start, 3) && !$past(busy, 3) && $past(rst_n, 1) && $past(rst_n, 2)
     && $past(rst_n, 3)) |-> out_valid)
    else $error("accepted word did not produce a result");

  // No result without a matching accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, 3) && !$past(busy, 3)))
    else $error("result without an accepted word");

  // Result fields belong to the word that gave the result.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_jump_target == $past(in_instr_word[25:0], 3)
                   && out_cop_number == $past(in_instr_word[27:26], 3)
                   && out_rs_field == $past(in_instr_word[25:21], 3)
                   && out_rt_field == $past(in_instr_word[20:16], 3)
                   && out_rd_field == $past(in_instr_word[15:11], 3)
                   && out_shift_amount == $past(in_instr_word[10:6], 3)
                   && out_funct_field == $past(in_instr_word[5:0], 3)
                   && out_imm_value == $past(in_instr_word[15:0], 3)))
    else $error("result fields do not follow the word");

  // Invalid flag and op code agree, class stays in range.
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_invalid == (out_op_code == OP_NONE)
                   && out_format_class <= CLS_COP))
    else $error("invalid flag, op code or class inconsistent");

endmodule

bind mips3_instruction_decoder m3dec_chk u_m3dec_chk (.*);
